>>> hw/rtl/ptt_pkg.sv
package ptt_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  localparam logic [2:0] OP_SET    = 3'd0;
  localparam logic [2:0] OP_KILL   = 3'd1;
  localparam logic [2:0] OP_CLEAR  = 3'd2;
  localparam logic [2:0] OP_CHECK  = 3'd3;
  localparam logic [2:0] OP_TAKE   = 3'd4;
  localparam logic [2:0] OP_DROP   = 3'd5;
  localparam logic [2:0] OP_COUNT  = 3'd6;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] now;
    logic [31:0] owner;
    logic [31:0] window;
    logic [31:0] message;
    logic [31:0] timer_id;
    logic [31:0] period;
    logic [31:0] proc_handle;
    logic        take_clears;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] out_window;
    logic [31:0] out_message;
    logic [31:0] out_id;
    logic [31:0] out_proc;
    logic [4:0]  active_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0] owner;
    logic [31:0] window;
    logic [31:0] message;
    logic [31:0] ident;
    logic [31:0] period;
    logic [31:0] start;
    logic [31:0] proc_handle;
  } entry_t;

endpackage

>>> hw/rtl/periodic_timer_table_top.sv
// Periodic timer table.
// Requests arrive on req_valid/req_ready with a req_t payload; each request
// gives exactly one response on rsp_valid/rsp_ready with an rsp_t payload.
// Timer fields live in one synchronous memory of SLOTS entries; valid and
// signaled bits and the active count are flip-flops.
// Set, kill, clear owner, check and take scan the memory from the head slot,
// one read per cycle, with the compare in the cycle after the read. A scan
// reads at most SLOTS slots and stops early on the first match except for
// clear owner; the finish state then writes back and loads the response.
// A request is accepted while idle. Drop and count skip the scan.
// One request is in work at a time; req_ready is high only while idle. A
// finished response waits in the output register; a new request is accepted
// while it waits, and the write-back of that request holds until the
// response register is free, so a stalled receiver stalls the table.
// Reset empties the table, clears all signals and sets the head slot to 0;
// no memory clearing pass is needed.
module periodic_timer_table_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  ptt_pkg::req_t  req_data,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output ptt_pkg::rsp_t  rsp_data
);

  localparam int SLOTS  = ptt_pkg::SLOTS;
  localparam int SLOT_W = ptt_pkg::SLOT_W;
  localparam int CNT_W  = ptt_pkg::CNT_W;

  ptt_pkg::state_t state, state_next;
  ptt_pkg::req_t   req_q;
  ptt_pkg::entry_t mem [SLOTS];
  ptt_pkg::entry_t mem_q;
  ptt_pkg::entry_t found_ent;
  ptt_pkg::entry_t wr_data;

  logic [SLOTS-1:0]  valid;
  logic [SLOTS-1:0]  sig;
  logic [SLOT_W-1:0] head;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  issue_cnt;
  logic [SLOT_W-1:0] rd_addr;
  logic              eval_vld;
  logic              eval_last;
  logic [SLOT_W-1:0] eval_slot;
  logic              found;
  logic [SLOT_W-1:0] found_slot;

  logic              issue_en;
  logic              match;
  logic              hit;
  logic              scan_end;
  logic              fin_go;
  logic              needs_scan;
  logic              free_any;
  logic [SLOT_W-1:0] free_slot;
  logic [SLOT_W-1:0] set_slot;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [31:0]       elapsed;
  ptt_pkg::rsp_t     rsp_next;
  logic [CNT_W-1:0]  cnt_fin;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    r = (s == SLOT_W'(SLOTS - 1)) ? '0 : s + SLOT_W'(1);
    return r;
  endfunction

  // Decode which requests walk the memory
  always_comb begin
    needs_scan = (req_data.op == ptt_pkg::OP_SET) || (req_data.op == ptt_pkg::OP_KILL) ||
                 (req_data.op == ptt_pkg::OP_CLEAR) || (req_data.op == ptt_pkg::OP_CHECK) ||
                 (req_data.op == ptt_pkg::OP_TAKE);
  end

  // Compare the entry read last cycle
  always_comb begin
    elapsed = req_q.now - mem_q.start;
    match   = 1'b0;
    unique case (req_q.op)
      ptt_pkg::OP_SET:   match = valid[eval_slot] && mem_q.ident == req_q.timer_id &&
                                 mem_q.window == req_q.window;
      ptt_pkg::OP_KILL:  match = valid[eval_slot] && mem_q.window == req_q.window &&
                                 mem_q.message == req_q.message &&
                                 mem_q.ident == req_q.timer_id;
      ptt_pkg::OP_CLEAR: match = valid[eval_slot] && mem_q.owner == req_q.owner;
      ptt_pkg::OP_CHECK: match = valid[eval_slot] && !sig[eval_slot] &&
                                 elapsed >= mem_q.period;
      ptt_pkg::OP_TAKE:  match = valid[eval_slot] && sig[eval_slot];
      default:           match = 1'b0;
    endcase
    hit      = eval_vld && match && (req_q.op != ptt_pkg::OP_CLEAR);
    scan_end = hit || (eval_vld && eval_last);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ptt_pkg::ST_IDLE: if (req_valid) state_next = needs_scan ? ptt_pkg::ST_SCAN
                                                               : ptt_pkg::ST_FIN;
      ptt_pkg::ST_SCAN: if (scan_end) state_next = ptt_pkg::ST_FIN;
      ptt_pkg::ST_FIN:  if (fin_go) state_next = ptt_pkg::ST_IDLE;
      default:          state_next = ptt_pkg::ST_IDLE;
    endcase
  end

  // Handshake and read control
  always_comb begin
    req_ready = (state == ptt_pkg::ST_IDLE);
    issue_en  = (state == ptt_pkg::ST_SCAN) && (issue_cnt < CNT_W'(SLOTS)) && !hit;
    fin_go    = (state == ptt_pkg::ST_FIN) && (!rsp_valid || rsp_ready);
  end

  // Find the lowest free slot
  always_comb begin
    free_any  = 1'b0;
    free_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_any  = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
    set_slot = found ? found_slot : free_slot;
  end

  // Build the write-back and the response
  always_comb begin
    rsp_next              = '0;
    cnt_fin               = cnt;
    wr_en                 = 1'b0;
    wr_addr               = set_slot;
    wr_data               = found_ent;
    wr_data.start         = req_q.now;
    unique case (req_q.op)
      ptt_pkg::OP_SET: begin
        if (found || free_any) begin
          wr_en               = 1'b1;
          wr_data.owner       = req_q.owner;
          wr_data.window      = req_q.window;
          wr_data.message     = req_q.message;
          wr_data.ident       = (req_q.window != '0) ? req_q.timer_id
                                                     : 32'(set_slot) + 32'd1;
          wr_data.period      = (req_q.period != '0) ? req_q.period : 32'd1;
          wr_data.proc_handle = req_q.proc_handle;
          rsp_next.ok         = 1'b1;
          rsp_next.out_id     = wr_data.ident;
          if (!found) cnt_fin = cnt + CNT_W'(1);
        end
      end
      ptt_pkg::OP_KILL: begin
        rsp_next.ok = found;
        if (found) cnt_fin = cnt - CNT_W'(1);
      end
      ptt_pkg::OP_CLEAR, ptt_pkg::OP_CHECK: rsp_next.ok = found;
      ptt_pkg::OP_TAKE: begin
        wr_addr = found_slot;
        wr_en   = found && req_q.take_clears;
        if (found) begin
          rsp_next.ok          = 1'b1;
          rsp_next.out_window  = found_ent.window;
          rsp_next.out_message = found_ent.message;
          rsp_next.out_id      = found_ent.ident;
          rsp_next.out_proc    = found_ent.proc_handle;
        end
      end
      ptt_pkg::OP_DROP: rsp_next.ok = (cnt != '0) && valid[head];
      default: rsp_next.ok = 1'b0;
    endcase
    rsp_next.active_count = 5'(cnt_fin);
  end

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (issue_en) mem_q <= mem[rd_addr];
    if (fin_go && wr_en) mem[wr_addr] <= wr_data;
  end

  // Capture the matching entry
  always_ff @(posedge clk) begin
    if (hit) begin
      found_slot <= eval_slot;
      found_ent  <= mem_q;
    end
  end

  // Request register and scan bookkeeping
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) req_q <= req_data;
    if (issue_en) begin
      eval_slot <= rd_addr;
      eval_last <= (issue_cnt == CNT_W'(SLOTS - 1));
    end
    if (req_valid && req_ready) rd_addr <= head;
    else if (issue_en) rd_addr <= next_slot(rd_addr);
    if (fin_go) rsp_data <= rsp_next;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ptt_pkg::ST_IDLE;
      valid     <= '0;
      sig       <= '0;
      head      <= '0;
      cnt       <= '0;
      issue_cnt <= '0;
      eval_vld  <= 1'b0;
      found     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      eval_vld <= issue_en;
      if (req_valid && req_ready) begin
        issue_cnt <= '0;
        found     <= 1'b0;
      end else if (issue_en) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
      end
      if (hit) found <= 1'b1;
      // Drop owner matches as the scan passes them
      if (state == ptt_pkg::ST_SCAN && eval_vld && match &&
          req_q.op == ptt_pkg::OP_CLEAR) begin
        valid[eval_slot] <= 1'b0;
        sig[eval_slot]   <= 1'b0;
        cnt              <= cnt - CNT_W'(1);
        found            <= 1'b1;
      end
      // Load a new response or release the accepted one
      if (fin_go) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      if (fin_go) begin
        cnt       <= cnt_fin;
        unique case (req_q.op)
          ptt_pkg::OP_SET: begin
            if (!found && free_any) begin
              valid[free_slot] <= 1'b1;
              sig[free_slot]   <= 1'b0;
              head             <= free_slot;
            end
          end
          ptt_pkg::OP_KILL: begin
            if (found) begin
              valid[found_slot] <= 1'b0;
              sig[found_slot]   <= 1'b0;
            end
          end
          ptt_pkg::OP_CHECK: begin
            if (found) begin
              sig[found_slot] <= 1'b1;
              head            <= found_slot;
            end
          end
          ptt_pkg::OP_TAKE: begin
            if (found) begin
              if (req_q.take_clears) sig[found_slot] <= 1'b0;
              head <= next_slot(found_slot);
            end
          end
          ptt_pkg::OP_DROP: begin
            if (cnt != '0) begin
              sig[head] <= 1'b0;
              head      <= next_slot(head);
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Active count tracks the valid bits
  assert property (@(posedge clk) disable iff (rst) cnt == CNT_W'($countones(valid)))
    else $error("active count out of step with valid bits");

  // A scan never issues more than one read per slot
  assert property (@(posedge clk) disable iff (rst) issue_cnt <= CNT_W'(SLOTS))
    else $error("scan issued too many reads");

  // An accepted request leaves idle
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state != ptt_pkg::ST_IDLE)
    else $error("request accepted without work");

  // A response loads only from the finish state
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ptt_pkg::ST_FIN)
    else $error("response without finish");

endmodule
